>>> rtl/cascaded_position_speed_pid_top_assert.svh
// Assertion macros for the cascaded position/speed PID controller
`ifndef CASCADED_POSITION_SPEED_PID_TOP_ASSERT_SVH
`define CASCADED_POSITION_SPEED_PID_TOP_ASSERT_SVH

// same-cycle implication
`define CPSPID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPSPID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cpspid_pkg.sv
// Shared widths, register codes and helpers for the cascaded PID controller
package cpspid_pkg;

    localparam int GAIN_W      = 16;
    localparam int POS_W       = 32;
    localparam int SPD_W       = 16;
    localparam int DRV_OUT_W   = 16;
    localparam int SP_W        = 32;
    localparam int ERR_W       = 33;
    localparam int DIF_W       = 34;
    localparam int SUM_W       = 48;
    localparam int ACC_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_GAINS   = 6;

    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int DRIVE_WIDTH_DEF    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_GAIN_P,
        REG_POS_GAIN_I,
        REG_POS_GAIN_D,
        REG_SPD_GAIN_P,
        REG_SPD_GAIN_I,
        REG_SPD_GAIN_D
    } gain_idx_t;

    typedef logic signed [GAIN_W-1:0] gain_t;
    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic signed [DIF_W-1:0]  dif_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    // saturate a one-bit-grown integrator sum back to SUM_W bits
    function automatic sum_t sat_sum(input logic signed [SUM_W:0] x);
        sum_t r;
        if (x[SUM_W] != x[SUM_W-1])
            r = x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            r = x[SUM_W-1:0];
        return r;
    endfunction

endpackage

>>> rtl/cpspid_if.sv
// Request channel interfaces for the cascaded PID controller
interface cpspid_sample_if import cpspid_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] position_target;
    logic signed [POS_W-1:0] position_measured;
    logic signed [SPD_W-1:0] speed_measured;

    modport source (output valid, position_target, position_measured, speed_measured,
                    input ready);
    modport sink   (input valid, position_target, position_measured, speed_measured,
                    output ready);
endinterface

interface cpspid_result_if import cpspid_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [DRV_OUT_W-1:0] drive_value;
    logic signed [SP_W-1:0]      speed_setpoint;

    modport source (output valid, drive_value, speed_setpoint, input ready);
    modport sink   (input valid, drive_value, speed_setpoint, output ready);
endinterface

interface cpspid_cfg_if import cpspid_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/cascaded_position_speed_pid_top.sv
// Cascaded position/speed PID controller top level
// One request carries a position target, measured position and measured speed; the
// outer position PID yields a 32-bit speed setpoint and the inner speed PID a drive
// value, both returned in one result. Gains are signed Q8.8, written through the cfg
// channel (index 0..5: position P, I, D, speed P, I, D; other indices ignored; always
// ready). A single shared 16x48 multiplier with a 64-bit accumulator forms all six
// products in turn, so a request is not accepted until the previous one has finished,
// and is held off further while a previous result is still waiting to be taken.
module cascaded_position_speed_pid_top
    import cpspid_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int DRIVE_WIDTH    = DRIVE_WIDTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    cpspid_sample_if.sink   sample,
    cpspid_result_if.source result,
    cpspid_cfg_if.sink      cfg
);

    localparam acc_t SP_MAX  = acc_t'(64'sd2147483647);
    localparam acc_t SP_MIN  = -SP_MAX - acc_t'(64'sd1);
    localparam acc_t DRV_MAX = (acc_t'(64'sd1) <<< (DRIVE_WIDTH - 1)) - acc_t'(64'sd1);
    localparam acc_t DRV_MIN = -DRV_MAX - acc_t'(64'sd1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_INT,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_ACC,
        S_SAT,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   loop_spd_reg;

    gain_t gain_reg [NUM_GAINS];

    sum_t pos_sum_reg, spd_sum_reg;
    err_t pos_new_reg, pos_old_reg, spd_new_reg, spd_old_reg;

    logic signed [POS_W-1:0] tgt_reg, meas_reg;
    logic signed [SPD_W-1:0] spd_reg;
    err_t err_reg;
    dif_t dif_reg;
    acc_t prod_reg, acc_reg;
    logic signed [SP_W-1:0]      setpoint_reg;
    logic signed [DRV_OUT_W-1:0] drive_reg;

    logic                        out_valid_reg;
    logic signed [DRV_OUT_W-1:0] out_drive_reg;
    logic signed [SP_W-1:0]      out_sp_reg;

    gain_idx_t   gain_sel;
    gain_t       mul_a;
    sum_t        mul_b;
    acc_t        prod_next;
    err_t        err_next;
    sum_t        sum_cur, sum_next;
    err_t        new_cur, old_cur;
    acc_t        shifted;
    logic signed [SP_W-1:0]      sp_clamped;
    logic signed [DRV_OUT_W-1:0] drv_clamped;

    assign sample.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;

    assign result.valid          = out_valid_reg;
    assign result.drive_value    = out_drive_reg;
    assign result.speed_setpoint = out_sp_reg;

    assign sum_cur = loop_spd_reg ? spd_sum_reg : pos_sum_reg;
    assign new_cur = loop_spd_reg ? spd_new_reg : pos_new_reg;
    assign old_cur = loop_spd_reg ? spd_old_reg : pos_old_reg;
    assign sum_next = sat_sum({sum_cur[SUM_W-1], sum_cur} +
                              {{(SUM_W+1-ERR_W){err_reg[ERR_W-1]}}, err_reg});

    always_comb
    begin
        if (loop_spd_reg)
            err_next = {setpoint_reg[SP_W-1], setpoint_reg} -
                       {{(ERR_W-SPD_W){spd_reg[SPD_W-1]}}, spd_reg};
        else
            err_next = {tgt_reg[POS_W-1], tgt_reg} - {meas_reg[POS_W-1], meas_reg};
    end

    always_comb
    begin
        gain_sel = REG_POS_GAIN_P;
        mul_b    = '0;
        case (state_reg)
            S_MUL_P:
            begin
                gain_sel = loop_spd_reg ? REG_SPD_GAIN_P : REG_POS_GAIN_P;
                mul_b    = {{(SUM_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
            end
            S_MUL_I:
            begin
                gain_sel = loop_spd_reg ? REG_SPD_GAIN_I : REG_POS_GAIN_I;
                mul_b    = sum_cur;
            end
            S_MUL_D:
            begin
                gain_sel = loop_spd_reg ? REG_SPD_GAIN_D : REG_POS_GAIN_D;
                mul_b    = {{(SUM_W-DIF_W){dif_reg[DIF_W-1]}}, dif_reg};
            end
            default:
            begin
                gain_sel = REG_POS_GAIN_P;
                mul_b    = '0;
            end
        endcase
    end

    assign mul_a     = gain_reg[gain_sel];
    assign prod_next = mul_a * mul_b;

    assign shifted = acc_reg >>> GAIN_FRAC_BITS;

    always_comb
    begin
        if (shifted > SP_MAX)
            sp_clamped = SP_MAX[SP_W-1:0];
        else if (shifted < SP_MIN)
            sp_clamped = SP_MIN[SP_W-1:0];
        else
            sp_clamped = shifted[SP_W-1:0];

        if (shifted > DRV_MAX)
            drv_clamped = DRV_MAX[DRV_OUT_W-1:0];
        else if (shifted < DRV_MIN)
            drv_clamped = DRV_MIN[DRV_OUT_W-1:0];
        else
            drv_clamped = shifted[DRV_OUT_W-1:0];
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            tgt_reg  <= sample.position_target;
            meas_reg <= sample.position_measured;
            spd_reg  <= sample.speed_measured;
        end
        if (state_reg == S_ERR)
            err_reg <= err_next;
        if (state_reg == S_INT)
            dif_reg <= {new_cur[ERR_W-1], new_cur} - {old_cur[ERR_W-1], old_cur};
        prod_reg <= prod_next;
        case (state_reg)
            S_INT:           acc_reg <= '0;
            S_MUL_I, S_MUL_D,
            S_ACC:           acc_reg <= acc_reg + prod_reg;
            default:         acc_reg <= acc_reg;
        endcase
        if (state_reg == S_SAT && !loop_spd_reg)
            setpoint_reg <= sp_clamped;
        if (state_reg == S_SAT && loop_spd_reg)
            drive_reg <= drv_clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            loop_spd_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_drive_reg <= '0;
            out_sp_reg    <= '0;
            pos_sum_reg   <= '0;
            pos_new_reg   <= '0;
            pos_old_reg   <= '0;
            spd_sum_reg   <= '0;
            spd_new_reg   <= '0;
            spd_old_reg   <= '0;
            for (int i = 0; i < NUM_GAINS; i++)
                gain_reg[i] <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.index < CFG_IDX_W'(NUM_GAINS))
                gain_reg[cfg.index] <= cfg.data;

            if (state_reg == S_DONE && (!out_valid_reg || result.ready))
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample.valid)
                    begin
                        loop_spd_reg <= 1'b0;
                        state_reg    <= S_ERR;
                    end
                end
                S_ERR:
                    state_reg <= S_INT;
                S_INT:
                begin
                    if (loop_spd_reg)
                    begin
                        spd_sum_reg <= sum_next;
                        spd_old_reg <= spd_new_reg;
                        spd_new_reg <= err_reg;
                    end
                    else
                    begin
                        pos_sum_reg <= sum_next;
                        pos_old_reg <= pos_new_reg;
                        pos_new_reg <= err_reg;
                    end
                    state_reg <= S_MUL_P;
                end
                S_MUL_P:
                    state_reg <= S_MUL_I;
                S_MUL_I:
                    state_reg <= S_MUL_D;
                S_MUL_D:
                    state_reg <= S_ACC;
                S_ACC:
                    state_reg <= S_SAT;
                S_SAT:
                begin
                    if (loop_spd_reg)
                        state_reg <= S_DONE;
                    else
                    begin
                        loop_spd_reg <= 1'b1;
                        state_reg    <= S_ERR;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_drive_reg <= drive_reg;
                        out_sp_reg    <= setpoint_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/cpspid_checker.sv
// Port-level assertion checker for the cascaded PID controller, with its bind
`include "cascaded_position_speed_pid_top_assert.svh"

module cpspid_checker
    import cpspid_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 sample_valid,
    input logic                 sample_ready,
    input logic                 result_valid,
    input logic                 result_ready,
    input logic [DRV_OUT_W-1:0] drive_value,
    input logic [SP_W-1:0]      speed_setpoint
);

    `CPSPID_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid,
        "result dropped while stalled")
    `CPSPID_ASSERT_NEXT(a_payload_held, result_valid && !result_ready,
        $stable(drive_value) && $stable(speed_setpoint), "result payload changed while stalled")
    `CPSPID_ASSERT_NEXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready,
        "ready again straight after a request")
    `CPSPID_ASSERT_NOW(a_ready_with_result, $rose(result_valid), sample_ready,
        "result raised while still busy")

endmodule

bind cascaded_position_speed_pid_top cpspid_checker u_cpspid_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_valid   (sample.valid),
    .sample_ready   (sample.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .drive_value    (result.drive_value),
    .speed_setpoint (result.speed_setpoint)
);

>>> sim/tb_cascaded_position_speed_pid_top.sv
// Self-checking testbench for the cascaded position/speed PID: directed table, random gains, windup
`timescale 1ns / 100ps

module tb_cascaded_position_speed_pid_top;
    import cpspid_pkg::*;

    localparam logic signed [POS_W-1:0]     POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0]     POS_MIN = 32'sh8000_0000;
    localparam logic signed [SPD_W-1:0]     SPD_MAX = 16'sh7FFF;
    localparam logic signed [SPD_W-1:0]     SPD_MIN = 16'sh8000;
    localparam logic signed [DRV_OUT_W-1:0] DRV_MAX = 16'sh7FFF;
    localparam logic signed [DRV_OUT_W-1:0] DRV_MIN = 16'sh8000;
    localparam gain_t                       GAIN_MAX = 16'sh7FFF;
    localparam gain_t                       GAIN_MIN = 16'sh8000;

    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = CFG_IDX_W'(NUM_GAINS);
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = CFG_IDX_W'(NUM_GAINS + 1);

    localparam acc_t SUM_HI = (acc_t'(1) <<< (SUM_W - 1)) - acc_t'(1);
    localparam acc_t SUM_LO = -SUM_HI - acc_t'(1);
    localparam acc_t SP_HI  = (acc_t'(1) <<< (SP_W - 1)) - acc_t'(1);
    localparam acc_t SP_LO  = -SP_HI - acc_t'(1);
    localparam acc_t DRV_HI = (acc_t'(1) <<< (DRIVE_WIDTH_DEF - 1)) - acc_t'(1);
    localparam acc_t DRV_LO = -DRV_HI - acc_t'(1);

    localparam int RANDOM_PHASES    = 14;
    localparam int PHASE_REQUESTS   = 100;
    localparam int WINDUP_REQUESTS  = 40;
    localparam int HOLDOFF_CYCLES   = 400;
    localparam int TAIL_CYCLES      = 40;
    localparam int PRINT_CAP        = 40;

    typedef struct {
        logic signed [POS_W-1:0] tgt;
        logic signed [POS_W-1:0] meas;
        logic signed [SPD_W-1:0] spd;
    } sample_t;

    typedef struct {
        logic signed [DRV_OUT_W-1:0] drive;
        logic signed [SP_W-1:0]      setpoint;
    } result_t;

    typedef struct {
        int                          phase;
        logic signed [POS_W-1:0]     tgt;
        logic signed [POS_W-1:0]     meas;
        logic signed [SPD_W-1:0]     spd;
        bit                          pinned;
        logic signed [DRV_OUT_W-1:0] drive;
        logic signed [SP_W-1:0]      setpoint;
    } step_row_t;

    // phase 0 is the reset state and is never written
    localparam gain_t DIRECTED_GAINS [5][NUM_GAINS] = '{
        '{0, 0, 0, 0, 0, 0},
        '{GAIN_MAX, 0, 0, GAIN_MAX, 0, 0},
        '{GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX},
        '{GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN},
        '{256, 16, -64, 128, 4, 32}
    };

    // outer sum winds up positive, inner sum negative
    localparam gain_t WINDUP_GAINS [NUM_GAINS] = '{0, -1, 0, 0, 1, 0};

    step_row_t directed_steps [20] = '{
        '{0, POS_MAX, POS_MIN, SPD_MAX, 1'b1, 0, 0},
        '{0, POS_MIN, POS_MAX, SPD_MIN, 1'b1, 0, 0},
        '{0, 0, 0, 0, 1'b1, 0, 0},
        '{1, POS_MAX, POS_MIN, 0, 1'b1, DRV_MAX, POS_MAX},
        '{1, POS_MIN, POS_MAX, 0, 1'b1, DRV_MIN, POS_MIN},
        '{1, 0, 0, SPD_MIN, 1'b1, DRV_MAX, 0},
        '{1, 0, 0, SPD_MAX, 1'b1, DRV_MIN, 0},
        '{1, 3, 1, 5, 1'b0, 0, 0},
        '{2, POS_MAX, POS_MIN, SPD_MIN, 1'b0, 0, 0},
        '{2, POS_MIN, POS_MAX, SPD_MAX, 1'b0, 0, 0},
        '{2, -5, 7, -1, 1'b0, 0, 0},
        '{3, POS_MAX, 0, SPD_MAX, 1'b0, 0, 0},
        '{3, POS_MIN, POS_MIN, 0, 1'b0, 0, 0},
        '{3, 12345, -54321, 300, 1'b0, 0, 0},
        '{4, 1000, 0, 0, 1'b0, 0, 0},
        '{4, 1000, 400, -20, 1'b0, 0, 0},
        '{4, -200, 300, 50, 1'b0, 0, 0},
        '{4, 0, 0, 0, 1'b0, 0, 0},
        '{4, 0, 0, 0, 1'b0, 0, 0},
        '{4, 32'sh0001_0000, 0, SPD_MIN, 1'b0, 0, 0}
    };

    logic clk;
    logic rst_n;

    cpspid_sample_if sample_ch ();
    cpspid_result_if result_ch ();
    cpspid_cfg_if    cfg_ch ();

    cascaded_position_speed_pid_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    gain_t gain_reg [NUM_GAINS] = '{default: 0};
    sum_t  pos_sum = '0;
    err_t  pos_new = '0;
    err_t  pos_old = '0;
    sum_t  spd_sum = '0;
    err_t  spd_new = '0;
    err_t  spd_old = '0;

    result_t outputs_due [$];
    int      mismatches   = 0;
    int      results_seen = 0;
    bit      steady       = 1'b0;
    int      hold_cycles  = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #40_000_000;
        $display("tb_cascaded_position_speed_pid_top: done, errors");
        $finish;
    end

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: %s", $time, what);
    endtask

    function automatic acc_t pid_update(input err_t err, inout sum_t sum, inout err_t newest,
                                        inout err_t older, input gain_t kp, input gain_t ki,
                                        input gain_t kd);
        acc_t grown;
        acc_t slope;
        acc_t acc;
        grown = acc_t'(sum) + acc_t'(err);
        if (grown > SUM_HI)
            grown = SUM_HI;
        else if (grown < SUM_LO)
            grown = SUM_LO;
        sum = sum_t'(grown);
        // derivative uses the history before this sample is shifted in
        slope = acc_t'(newest) - acc_t'(older);
        older = newest;
        newest = err;
        acc = acc_t'(kp) * acc_t'(err) + acc_t'(ki) * acc_t'(sum) + acc_t'(kd) * slope;
        return acc >>> GAIN_FRAC_BITS_DEF;
    endfunction

    function automatic result_t control_step(sample_t s);
        acc_t    sp;
        acc_t    drv;
        result_t r;
        sp = pid_update(err_t'(acc_t'(s.tgt) - acc_t'(s.meas)), pos_sum, pos_new, pos_old,
                        gain_reg[REG_POS_GAIN_P], gain_reg[REG_POS_GAIN_I],
                        gain_reg[REG_POS_GAIN_D]);
        if (sp > SP_HI)
            sp = SP_HI;
        else if (sp < SP_LO)
            sp = SP_LO;
        drv = pid_update(err_t'(sp - acc_t'(s.spd)), spd_sum, spd_new, spd_old,
                         gain_reg[REG_SPD_GAIN_P], gain_reg[REG_SPD_GAIN_I],
                         gain_reg[REG_SPD_GAIN_D]);
        if (drv > DRV_HI)
            drv = DRV_HI;
        else if (drv < DRV_LO)
            drv = DRV_LO;
        r.setpoint = sp[SP_W-1:0];
        r.drive    = drv[DRV_OUT_W-1:0];
        return r;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s.tgt = POS_W'($urandom);
        if ($urandom_range(3) == 0)
        begin
            s.meas = POS_W'($urandom);
            s.spd  = SPD_W'($urandom);
        end
        else
        begin
            s.meas = s.tgt + POS_W'($urandom_range(8191)) - POS_W'(4096);
            s.spd  = SPD_W'($urandom_range(2047)) - SPD_W'(1024);
        end
        return s;
    endfunction

    function automatic gain_t random_gain();
        case ($urandom_range(5))
            0:       return GAIN_MAX;
            1:       return GAIN_MIN;
            2:       return gain_t'($urandom);
            default: return gain_t'(int'($urandom_range(1023)) - 512);
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, gain_t value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx < NUM_GAINS)
            gain_reg[idx] = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_sample(sample_t s, bit pinned, result_t pinned_res);
        result_t predicted;
        @(negedge clk);
        while (!steady && $urandom_range(99) < 14)
        begin
            sample_ch.valid             <= 1'b0;
            sample_ch.position_target   <= POS_W'($urandom);
            sample_ch.position_measured <= POS_W'($urandom);
            sample_ch.speed_measured    <= SPD_W'($urandom);
            @(negedge clk);
        end
        sample_ch.valid             <= 1'b1;
        sample_ch.position_target   <= s.tgt;
        sample_ch.position_measured <= s.meas;
        sample_ch.speed_measured    <= s.spd;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        predicted = control_step(s);
        outputs_due.push_back(pinned ? pinned_res : predicted);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (outputs_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
                result_ch.ready <= steady || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (outputs_due.size() == 0)
                report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                          results_seen));
            else
            begin
                want = outputs_due.pop_front();
                if (result_ch.drive_value !== want.drive)
                    report_mismatch($sformatf("result %0d drive_value got %0d expected %0d",
                                              results_seen, result_ch.drive_value,
                                              want.drive));
                if (result_ch.speed_setpoint !== want.setpoint)
                    report_mismatch($sformatf("result %0d speed_setpoint got %0d expected %0d",
                                              results_seen, result_ch.speed_setpoint,
                                              want.setpoint));
            end
        end
    end

    initial
    begin
        int        phase_now;
        sample_t   s;
        result_t   pin;

        rst_n                       = 1'b0;
        sample_ch.valid             = 1'b0;
        sample_ch.position_target   = '0;
        sample_ch.position_measured = '0;
        sample_ch.speed_measured    = '0;
        cfg_ch.valid                = 1'b0;
        cfg_ch.index                = '0;
        cfg_ch.data                 = '0;
        pin                         = '{0, 0};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // writes beyond the last gain must leave the zero reset gains alone
        write_reg(IDX_SPARE_A, GAIN_MAX);
        write_reg(IDX_SPARE_B, GAIN_MIN);

        phase_now = 0;
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].phase != phase_now)
            begin
                phase_now = directed_steps[i].phase;
                drain();
                for (int g = 0; g < NUM_GAINS; g++)
                    write_reg(gain_idx_t'(g), DIRECTED_GAINS[phase_now][g]);
            end
            s   = '{directed_steps[i].tgt, directed_steps[i].meas, directed_steps[i].spd};
            pin = '{directed_steps[i].drive, directed_steps[i].setpoint};
            send_sample(s, directed_steps[i].pinned, pin);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            steady = (p == 2);
            if (p == 5)
                hold_cycles = HOLDOFF_CYCLES;
            for (int g = 0; g < NUM_GAINS; g++)
                write_reg(gain_idx_t'(g), random_gain());
            write_reg($urandom_range(1) ? IDX_SPARE_A : IDX_SPARE_B, gain_t'($urandom));
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if ($urandom_range(99) == 0)
                    drain();
                send_sample(random_sample(), 1'b0, pin);
            end
        end

        // run at full error so both integrators wind hard
        drain();
        steady = 1'b1;
        for (int g = 0; g < NUM_GAINS; g++)
            write_reg(gain_idx_t'(g), WINDUP_GAINS[g]);
        s = '{POS_MAX, POS_MIN, SPD_MAX};
        for (int n = 0; n < WINDUP_REQUESTS; n++)
            send_sample(s, 1'b0, pin);
        drain();
        steady = 1'b0;

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_cascaded_position_speed_pid_top: done, clean");
        else
            $display("tb_cascaded_position_speed_pid_top: done, errors");
        $finish;
    end

endmodule
